// ===== rtl/sc2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2e_pkg
// Shared types, result kinds and escape sequence tables for the scancode
// to escape sequence translator.
// ----------------------------------------------------------------------------
package sc2e_pkg;

	// Result kinds carried on the output tuser field.
	localparam logic [1:0] KindEsc      = 2'd0;
	localparam logic [1:0] KindConsole  = 2'd1;
	localparam logic [1:0] KindModifier = 2'd2;
	localparam logic [1:0] KindRegular  = 2'd3;

	// Number of stored escape sequences: ten navigation keys, twelve function keys.
	localparam int SeqCount = 22;
	localparam logic [4:0] SeqFkeyBase = 5'd10;
	localparam logic [4:0] SeqF11      = 5'd20;
	localparam logic [4:0] SeqF12      = 5'd21;

	// Special scancodes.
	localparam logic [7:0] ScPrefix   = 8'hE0;
	localparam logic [7:0] ScAltMake  = 8'h38;
	localparam logic [7:0] ScAltBreak = 8'hB8;
	localparam logic [7:0] ScVirtLo   = 8'h60;
	localparam logic [7:0] ScVirtNav  = 8'h69;
	localparam logic [7:0] ScVirtHi   = 8'h6F;
	localparam logic [7:0] ScConsBase = 8'h3A;
	localparam logic [7:0] ScF1       = 8'h3B;
	localparam logic [7:0] ScF10      = 8'h44;
	localparam logic [7:0] ScF11      = 8'h57;
	localparam logic [7:0] ScF12      = 8'h58;

	// Sequence bytes, first byte in the lowest bits, unused bytes zero.
	localparam logic [39:0] SeqTable [SeqCount] = '{
		40'h00_00_41_5B_1B, // Up
		40'h00_00_42_5B_1B, // Down
		40'h00_00_43_5B_1B, // Right
		40'h00_00_44_5B_1B, // Left
		40'h00_00_48_5B_1B, // Home
		40'h00_00_46_5B_1B, // End
		40'h00_7E_35_5B_1B, // Page up
		40'h00_7E_36_5B_1B, // Page down
		40'h00_7E_32_5B_1B, // Insert
		40'h00_7E_33_5B_1B, // Delete
		40'h00_00_50_4F_1B, // F1
		40'h00_00_51_4F_1B, // F2
		40'h00_00_52_4F_1B, // F3
		40'h00_00_53_4F_1B, // F4
		40'h7E_35_31_5B_1B, // F5
		40'h7E_37_31_5B_1B, // F6
		40'h7E_38_31_5B_1B, // F7
		40'h7E_39_31_5B_1B, // F8
		40'h7E_30_32_5B_1B, // F9
		40'h7E_31_32_5B_1B, // F10
		40'h7E_33_32_5B_1B, // F11
		40'h7E_34_32_5B_1B  // F12
	};

	// Sequence lengths in bytes.
	localparam logic [2:0] SeqLen [SeqCount] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	// One classified command passed from the front to the back.
	typedef struct packed {
		logic       is_seq;  // 1: expand a stored sequence, 0: one single result
		logic [4:0] seq_idx; // sequence number when is_seq is set
		logic [1:0] kind;    // result kind of a single result
		logic [7:0] data;    // data of a single result
	} cmd_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

// ===== rtl/sc2e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2e_front
// Accepts scancodes, tracks the extension prefix and classifies each byte
// into a command for the back end.
// ----------------------------------------------------------------------------
module sc2e_front #(
	parameter int CONSOLE_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        scancode,
	input  logic              alt_held,
	input  logic              ctrl_held,
	input  logic              accept,
	output logic              push,
	output sc2e_pkg::cmd_t    cmd
);

	localparam logic [7:0] ConsLast = 8'(8'h3A + CONSOLE_COUNT - 1);

	logic       prefix_q;
	logic       prefix_next;
	logic       produce;
	logic       nav_hit;
	logic [4:0] nav_idx;

	// Extended navigation code lookup.
	always_comb begin
		nav_hit = 1'b1;
		nav_idx = 5'd0;
		case (scancode)
			8'h48: nav_idx = 5'd0;
			8'h50: nav_idx = 5'd1;
			8'h4D: nav_idx = 5'd2;
			8'h4B: nav_idx = 5'd3;
			8'h47: nav_idx = 5'd4;
			8'h4F: nav_idx = 5'd5;
			8'h49: nav_idx = 5'd6;
			8'h51: nav_idx = 5'd7;
			8'h52: nav_idx = 5'd8;
			8'h53: nav_idx = 5'd9;
			default: nav_hit = 1'b0;
		endcase
	end

	// Classification of the incoming byte in priority order.
	always_comb begin
		prefix_next = prefix_q;
		produce     = 1'b1;
		cmd.is_seq  = 1'b0;
		cmd.seq_idx = 5'd0;
		cmd.kind    = sc2e_pkg::KindRegular;
		cmd.data    = scancode;
		if (scancode == sc2e_pkg::ScAltMake || scancode == sc2e_pkg::ScAltBreak) begin
			cmd.kind = sc2e_pkg::KindModifier;
		end else if (scancode == sc2e_pkg::ScPrefix) begin
			prefix_next = 1'b1;
			produce     = 1'b0;
		end else if (prefix_q) begin
			prefix_next = 1'b0;
			produce     = nav_hit && !scancode[7];
			cmd.is_seq  = 1'b1;
			cmd.seq_idx = nav_idx;
		end else if (scancode >= sc2e_pkg::ScVirtLo && scancode <= sc2e_pkg::ScVirtHi) begin
			produce     = scancode <= sc2e_pkg::ScVirtNav;
			cmd.is_seq  = 1'b1;
			cmd.seq_idx = {1'b0, scancode[3:0]};
		end else if (alt_held && !ctrl_held && scancode >= sc2e_pkg::ScF1 &&
				scancode <= ConsLast) begin
			cmd.kind = sc2e_pkg::KindConsole;
			cmd.data = scancode - sc2e_pkg::ScConsBase;
		end else if (scancode >= sc2e_pkg::ScF1 && scancode <= sc2e_pkg::ScF10) begin
			cmd.is_seq  = 1'b1;
			cmd.seq_idx = sc2e_pkg::SeqFkeyBase + 5'(scancode - sc2e_pkg::ScF1);
		end else if (scancode == sc2e_pkg::ScF11) begin
			cmd.is_seq  = 1'b1;
			cmd.seq_idx = sc2e_pkg::SeqF11;
		end else if (scancode == sc2e_pkg::ScF12) begin
			cmd.is_seq  = 1'b1;
			cmd.seq_idx = sc2e_pkg::SeqF12;
		end
	end

	assign push = accept && produce;

	// Prefix flag advances on every accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
		end else if (accept) begin
			prefix_q <= prefix_next;
		end
	end

endmodule

// ===== rtl/sc2e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2e_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sc2e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sc2e_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output sc2e_pkg::cmd_t    head,
	output sc2e_pkg::q_stat_t stat
);

	sc2e_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/sc2e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2e_back
// Expands the command at the queue head into result transfers, one byte
// per cycle while m_tready does not stall it, through a registered output stage.
// ----------------------------------------------------------------------------
module sc2e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sc2e_pkg::cmd_t    head,
	input  logic              head_valid,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic       m_tvalid_q;
	logic [7:0] data_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic [2:0] pos_q;
	logic       load;
	logic       emit;
	logic       is_last;
	logic [7:0] emit_data;
	logic [1:0] emit_kind;

	assign load = !m_tvalid_q || m_tready;
	assign emit = load && head_valid;
	assign pop  = emit && is_last;

	// Select the byte for the current position of the head command.
	always_comb begin
		if (head.is_seq) begin
			emit_data = sc2e_pkg::SeqTable[head.seq_idx][{pos_q, 3'b000} +: 8];
			emit_kind = sc2e_pkg::KindEsc;
			is_last   = pos_q == sc2e_pkg::SeqLen[head.seq_idx] - 3'd1;
		end else begin
			emit_data = head.data;
			emit_kind = head.kind;
			is_last   = 1'b1;
		end
	end

	// Output register and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pos_q      <= 3'd0;
		end else if (load) begin
			m_tvalid_q <= head_valid;
			if (emit) begin
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	// Payload of the output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= emit_data;
			kind_q <= emit_kind;
			last_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

// ===== rtl/scancode_to_escape_sequence_top.sv =====
`timescale 1ns / 1ps
// Path: a result passes through the command queue and then the output register.
// Throughput: one result per cycle from the output register while m_tready is high;
// a scancode makes one to five results, or none.
// A two-entry command queue lets new scancodes enter while a sequence drains.
// Reset: arst_n clears the prefix flag, the queue and the output valid at once.
// ----------------------------------------------------------------------------
// scancode_to_escape_sequence_top
// Translates set-1 scancodes into escape bytes, console switches and
// forwarded keys.
// ----------------------------------------------------------------------------
module scancode_to_escape_sequence_top #(
	parameter int CONSOLE_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] scancode, [8] alt_held, [9] ctrl_held, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] data
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast
);

	sc2e_pkg::cmd_t    push_cmd;
	sc2e_pkg::cmd_t    head;
	sc2e_pkg::q_stat_t stat;
	logic              push;
	logic              pop;
	logic              accept;

	// The front stalls only when the queue is full.
	assign s_tready = !stat.full;
	assign accept   = s_tvalid && s_tready;

	sc2e_front #(
		.CONSOLE_COUNT(CONSOLE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.scancode (s_tdata[7:0]),
		.alt_held (s_tdata[8]),
		.ctrl_held(s_tdata[9]),
		.accept   (accept),
		.push     (push),
		.cmd      (push_cmd)
	);

	sc2e_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	sc2e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(stat.valid),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
